// File: hdl/tts_pkg.sv
// Package: types, codes and constants shared by the timeline sequencer modules.
package tts_pkg;

    localparam int POS_W        = 16;
    localparam int ALPHA_W      = 17;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int DEF_MAX_WRAPS = 8;
    localparam int DEF_TIME_BITS = 16;
    localparam int ALPHA_STEPS  = 16;

    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_PAUSE   = 3'd1;
    localparam logic [2:0] KIND_RESUME  = 3'd2;
    localparam logic [2:0] KIND_CANCEL  = 3'd3;
    localparam logic [2:0] KIND_RESTART = 3'd4;

    localparam logic [2:0] EV_STATUS       = 3'd0;
    localparam logic [2:0] EV_UPDATE       = 3'd1;
    localparam logic [2:0] EV_LOOPED       = 3'd2;
    localparam logic [2:0] EV_TURNED       = 3'd3;
    localparam logic [2:0] EV_COMPLETED    = 3'd4;
    localparam logic [2:0] EV_START_FINAL  = 3'd5;
    localparam logic [2:0] EV_CANCEL_FINAL = 3'd6;
    localparam logic [2:0] EV_CANCEL_PLAIN = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKWARD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd5;

    localparam logic [1:0] WRAP_LOOP     = 2'd1;
    localparam logic [1:0] WRAP_PINGPONG = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] elapsed;
        logic        apply_final;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         event_res;
        logic [POS_W-1:0]   position;
        logic [ALPHA_W-1:0] alpha;
        logic               running;
        logic               truncated;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] delay_ticks;
        logic [15:0] duration_ticks;
        logic [15:0] rate_scale;
        logic        start_backward;
        logic [1:0]  wrap_mode;
        logic [15:0] loop_limit;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] dur;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [ALPHA_W-1:0] alpha;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_SCALE,
        ST_DELAY,
        ST_LOOP,
        ST_BOUND,
        ST_BOUND_LOOP,
        ST_BOUND_PP,
        ST_EMIT,
        ST_DIVW,
        ST_END
    } state_t;

endpackage

// File: hdl/tween_timeline_sequencer_top.sv
// Top level: configuration registers, sequencer and shared alpha divider.
//
// Usage: items enter on s_valid/s_ready/s_data (kind, elapsed, apply_final);
// results leave on m_valid/m_ready/m_data, one or more per item, the final one
// flagged by last. Configuration registers are written through cfg_wr_en,
// cfg_index and cfg_wdata while no transaction is in flight; the delay and
// start position load at the next restart item; the rest apply at once.
// Flow: s_ready is high only while the sequencer is idle. An item passes
// through decode, for a tick also multiply, scale and delay, and end; each
// result adds the emit step and the 16-step shared divider that forms alpha
// (its steps skipped at or past the duration), and each boundary adds the
// bound step and, in loop or ping-pong mode, its follow-up step; a tick with
// MAX_WRAPS boundaries gives up to 2*MAX_WRAPS+2 results. Results leave
// through an output register and a one-entry staging register, so the
// sequencer keeps working until both are full while the receiver stalls.
// Reset (aresetn low, synchronous) restores default registers and the initial
// timeline state and drops any pending transaction.
module tween_timeline_sequencer_top #(
    parameter int MAX_WRAPS = tts_pkg::DEF_MAX_WRAPS,
    parameter int TIME_BITS = tts_pkg::DEF_TIME_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tts_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tts_pkg::out_item_t               m_data
);

    tts_pkg::cfg_t     cfg_reg;
    tts_pkg::div_req_t div_req;
    tts_pkg::div_rsp_t div_rsp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_ticks    <= '0;
            cfg_reg.duration_ticks <= 16'd1;
            cfg_reg.rate_scale     <= 16'd256;
            cfg_reg.start_backward <= 1'b0;
            cfg_reg.wrap_mode      <= '0;
            cfg_reg.loop_limit     <= '0;
        end else if (cfg_wr_en) begin
            priority case (cfg_index)
                tts_pkg::REG_DELAY:    cfg_reg.delay_ticks    <= cfg_wdata;
                tts_pkg::REG_DURATION: cfg_reg.duration_ticks <= cfg_wdata;
                tts_pkg::REG_RATE:     cfg_reg.rate_scale     <= cfg_wdata;
                tts_pkg::REG_BACKWARD: cfg_reg.start_backward <= cfg_wdata[0];
                tts_pkg::REG_WRAP:     cfg_reg.wrap_mode      <= cfg_wdata[1:0];
                tts_pkg::REG_LIMIT:    cfg_reg.loop_limit     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tts_ctrl #(
        .MAX_WRAPS(MAX_WRAPS),
        .TIME_BITS(TIME_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    tts_alpha_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    a_alpha_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.alpha <= 17'd65536)
        else $error("alpha above one");

    a_trunc_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.truncated |-> m_data.event_res == tts_pkg::EV_STATUS)
        else $error("truncated flag on non-status result");

    a_complete_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_res == tts_pkg::EV_COMPLETED |-> !m_data.running)
        else $error("completed result while running");

endmodule

// File: hdl/tts_alpha_div.sv
// Iterative restoring divider for alpha = min(65536, floor(pos * 65536 / dur)).
module tts_alpha_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  tts_pkg::div_req_t req,
    output tts_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(tts_pkg::ALPHA_STEPS + 1);

    logic                        busy_reg, busy_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        sat_reg, sat_next;
    logic [tts_pkg::POS_W:0]     rem_reg, rem_next;
    logic [tts_pkg::POS_W-1:0]   quo_reg, quo_next;
    logic [tts_pkg::POS_W-1:0]   dur_reg, dur_next;
    logic [tts_pkg::POS_W:0]     shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        sat_reg <= sat_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dur_reg <= dur_next;
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dur_next  = dur_reg;
        shifted   = {rem_reg[tts_pkg::POS_W-1:0], 1'b0};
        rsp.done  = busy_reg && (cnt_reg == '0);
        rsp.alpha = sat_reg ? (tts_pkg::ALPHA_W)'(1 << tts_pkg::POS_W)
                            : {1'b0, quo_reg};
        if (req.start) begin
            busy_next = 1'b1;
            sat_next  = req.pos >= req.dur;
            cnt_next  = (req.pos >= req.dur) ? '0 : CNT_W'(tts_pkg::ALPHA_STEPS);
            rem_next  = {1'b0, req.pos};
            quo_next  = '0;
            dur_next  = req.dur;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
                if (shifted >= {1'b0, dur_reg}) begin
                    rem_next = shifted - {1'b0, dur_reg};
                    quo_next = {quo_reg[tts_pkg::POS_W-2:0], 1'b1};
                end else begin
                    rem_next = shifted;
                    quo_next = {quo_reg[tts_pkg::POS_W-2:0], 1'b0};
                end
            end
        end
    end

endmodule

// File: hdl/tts_ctrl.sv
// Sequencer: timeline state, tick stepping, result staging and output register.
module tts_ctrl #(
    parameter int MAX_WRAPS = tts_pkg::DEF_MAX_WRAPS,
    parameter int TIME_BITS = tts_pkg::DEF_TIME_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tts_pkg::cfg_t      cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  tts_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tts_pkg::out_item_t m_data,
    output tts_pkg::div_req_t  div_req,
    input  tts_pkg::div_rsp_t  div_rsp
);

    localparam int XW = 34;
    localparam int WR_W = $clog2(MAX_WRAPS + 1);
    localparam logic [XW-1:0] CAP = (XW'(1) << TIME_BITS) - XW'(1);

    tts_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    tts_pkg::in_item_t item_reg, item_next;
    logic active_reg, active_next, paused_reg, paused_next;
    logic started_reg, started_next, fwd_reg, fwd_next;
    logic [15:0] delay_reg, delay_next;
    logic [tts_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0] cycles_reg, cycles_next, pairs_reg, pairs_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [WR_W-1:0] wraps_reg, wraps_next;
    logic [31:0] prod_reg, prod_next;
    logic [2:0] ev_reg, ev_next;
    logic trunc_reg, trunc_next;
    logic pend_v_reg, pend_v_next, out_v_reg, out_v_next;
    tts_pkg::out_item_t pend_reg, pend_next, out_reg, out_next;

    logic [15:0] dur;
    logic [XW-1:0] rem_x, pos_x, dur_x, dly_x, ttb_x, scaled_x;
    logic out_free;

    assign dur      = (cfg.duration_ticks == '0) ? 16'd1 : cfg.duration_ticks;
    assign rem_x    = XW'(rem_reg);
    assign pos_x    = XW'(pos_reg);
    assign dur_x    = XW'(dur);
    assign dly_x    = XW'(delay_reg);
    assign scaled_x = XW'(prod_reg[31:8]);
    assign out_free = !out_v_reg || m_ready;
    assign s_ready  = (state_reg == tts_pkg::ST_IDLE);
    assign m_valid  = out_v_reg;
    assign m_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tts_pkg::ST_IDLE;
            ret_reg     <= tts_pkg::ST_IDLE;
            active_reg  <= 1'b1;
            paused_reg  <= 1'b0;
            started_reg <= 1'b0;
            fwd_reg     <= 1'b1;
            delay_reg   <= '0;
            pos_reg     <= '0;
            cycles_reg  <= '0;
            pairs_reg   <= '0;
            pend_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            active_reg  <= active_next;
            paused_reg  <= paused_next;
            started_reg <= started_next;
            fwd_reg     <= fwd_next;
            delay_reg   <= delay_next;
            pos_reg     <= pos_next;
            cycles_reg  <= cycles_next;
            pairs_reg   <= pairs_next;
            pend_v_reg  <= pend_v_next;
            out_v_reg   <= out_v_next;
        end
        item_reg  <= item_next;
        rem_reg   <= rem_next;
        wraps_reg <= wraps_next;
        prod_reg  <= prod_next;
        ev_reg    <= ev_next;
        trunc_reg <= trunc_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        item_next    = item_reg;
        active_next  = active_reg;
        paused_next  = paused_reg;
        started_next = started_reg;
        fwd_next     = fwd_reg;
        delay_next   = delay_reg;
        pos_next     = pos_reg;
        cycles_next  = cycles_reg;
        pairs_next   = pairs_reg;
        rem_next     = rem_reg;
        wraps_next   = wraps_reg;
        prod_next    = prod_reg;
        ev_next      = ev_reg;
        trunc_next   = trunc_reg;
        pend_v_next  = pend_v_reg;
        pend_next    = pend_reg;
        out_v_next   = out_v_reg && !m_ready;
        out_next     = out_reg;
        ttb_x        = '0;
        div_req.start = 1'b0;
        div_req.pos   = pos_reg;
        div_req.dur   = dur;

        unique case (state_reg)
            tts_pkg::ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = tts_pkg::ST_DECODE;
                end
            end
            tts_pkg::ST_DECODE: begin
                state_next = tts_pkg::ST_END;
                priority case (item_reg.kind)
                    tts_pkg::KIND_TICK: begin
                        if (active_reg && !paused_reg) begin
                            state_next = tts_pkg::ST_MUL;
                            if (!started_reg) begin
                                started_next = 1'b1;
                                if (cfg.start_backward) begin
                                    ev_next    = tts_pkg::EV_START_FINAL;
                                    trunc_next = 1'b0;
                                    ret_next   = tts_pkg::ST_MUL;
                                    state_next = tts_pkg::ST_EMIT;
                                end
                            end
                        end
                    end
                    tts_pkg::KIND_PAUSE:  paused_next = 1'b1;
                    tts_pkg::KIND_RESUME: paused_next = 1'b0;
                    tts_pkg::KIND_CANCEL: begin
                        if (active_reg) begin
                            active_next = 1'b0;
                            ev_next     = item_reg.apply_final ? tts_pkg::EV_CANCEL_FINAL
                                                               : tts_pkg::EV_CANCEL_PLAIN;
                            trunc_next  = 1'b0;
                            ret_next    = tts_pkg::ST_END;
                            state_next  = tts_pkg::ST_EMIT;
                        end
                    end
                    tts_pkg::KIND_RESTART: begin
                        active_next  = 1'b1;
                        paused_next  = 1'b0;
                        started_next = 1'b0;
                        delay_next   = cfg.delay_ticks;
                        pos_next     = cfg.start_backward ? dur : '0;
                        fwd_next     = !cfg.start_backward;
                        cycles_next  = '0;
                        pairs_next   = '0;
                    end
                    default: state_next = tts_pkg::ST_END;
                endcase
            end
            tts_pkg::ST_MUL: begin
                prod_next  = 32'(item_reg.elapsed) * 32'(cfg.rate_scale);
                state_next = tts_pkg::ST_SCALE;
            end
            tts_pkg::ST_SCALE: begin
                rem_next   = (scaled_x > CAP) ? CAP[TIME_BITS-1:0]
                                              : scaled_x[TIME_BITS-1:0];
                state_next = tts_pkg::ST_DELAY;
            end
            tts_pkg::ST_DELAY: begin
                wraps_next = '0;
                state_next = tts_pkg::ST_LOOP;
                if (rem_reg == '0) begin
                    state_next = tts_pkg::ST_END;
                end else if (delay_reg != '0) begin
                    if (rem_x < dly_x) begin
                        delay_next = 16'(dly_x - rem_x);
                        state_next = tts_pkg::ST_END;
                    end else begin
                        rem_next   = TIME_BITS'(rem_x - dly_x);
                        delay_next = '0;
                    end
                end
            end
            tts_pkg::ST_LOOP: begin
                trunc_next = 1'b0;
                ev_next    = tts_pkg::EV_UPDATE;
                state_next = tts_pkg::ST_EMIT;
                ret_next   = tts_pkg::ST_END;
                if (rem_reg == '0 || !active_reg) begin
                    state_next = tts_pkg::ST_END;
                end else if (XW'(wraps_reg) >= XW'(MAX_WRAPS)) begin
                    ev_next    = tts_pkg::EV_STATUS;
                    trunc_next = 1'b1;
                end else if (fwd_reg) begin
                    if (pos_x + rem_x < dur_x) begin
                        pos_next = tts_pkg::POS_W'(pos_x + rem_x);
                    end else begin
                        ttb_x      = (pos_x > dur_x) ? pos_x - dur_x : dur_x - pos_x;
                        pos_next   = dur;
                        rem_next   = (rem_x > ttb_x) ? TIME_BITS'(rem_x - ttb_x) : '0;
                        wraps_next = wraps_reg + 1'b1;
                        ret_next   = tts_pkg::ST_BOUND;
                    end
                end else begin
                    if (rem_x < pos_x) begin
                        pos_next = tts_pkg::POS_W'(pos_x - rem_x);
                    end else begin
                        ttb_x      = pos_x;
                        pos_next   = '0;
                        rem_next   = (rem_x > ttb_x) ? TIME_BITS'(rem_x - ttb_x) : '0;
                        wraps_next = wraps_reg + 1'b1;
                        ret_next   = tts_pkg::ST_BOUND;
                    end
                end
            end
            tts_pkg::ST_BOUND: begin
                trunc_next = 1'b0;
                state_next = tts_pkg::ST_EMIT;
                if (cfg.wrap_mode == tts_pkg::WRAP_LOOP) begin
                    if (cycles_reg != 16'hFFFF) cycles_next = cycles_reg + 1'b1;
                    ev_next  = tts_pkg::EV_LOOPED;
                    ret_next = tts_pkg::ST_BOUND_LOOP;
                end else if (cfg.wrap_mode == tts_pkg::WRAP_PINGPONG) begin
                    fwd_next = !fwd_reg;
                    ev_next  = tts_pkg::EV_TURNED;
                    ret_next = tts_pkg::ST_BOUND_PP;
                end else begin
                    active_next = 1'b0;
                    ev_next     = tts_pkg::EV_COMPLETED;
                    ret_next    = tts_pkg::ST_END;
                end
            end
            tts_pkg::ST_BOUND_LOOP: begin
                if (cfg.loop_limit != '0 && cycles_reg >= cfg.loop_limit) begin
                    active_next = 1'b0;
                    ev_next     = tts_pkg::EV_COMPLETED;
                    ret_next    = tts_pkg::ST_END;
                    state_next  = tts_pkg::ST_EMIT;
                end else begin
                    pos_next   = cfg.start_backward ? dur : '0;
                    fwd_next   = !cfg.start_backward;
                    state_next = tts_pkg::ST_LOOP;
                end
            end
            tts_pkg::ST_BOUND_PP: begin
                state_next = tts_pkg::ST_LOOP;
                if (!fwd_reg) begin
                    if (pairs_reg != 16'hFFFF) pairs_next = pairs_reg + 1'b1;
                    pos_next = dur;
                end else if (cfg.loop_limit != '0 && pairs_reg >= cfg.loop_limit) begin
                    active_next = 1'b0;
                    ev_next     = tts_pkg::EV_COMPLETED;
                    ret_next    = tts_pkg::ST_END;
                    state_next  = tts_pkg::ST_EMIT;
                end else begin
                    pos_next = '0;
                end
            end
            tts_pkg::ST_EMIT: begin
                if (!pend_v_reg || out_free) begin
                    if (pend_v_reg) begin
                        out_next      = pend_reg;
                        out_next.last = 1'b0;
                        out_v_next    = 1'b1;
                    end
                    pend_v_next         = 1'b0;
                    pend_next.event_res = ev_reg;
                    pend_next.position  = pos_reg;
                    pend_next.running   = active_reg;
                    pend_next.truncated = trunc_reg;
                    pend_next.last      = 1'b0;
                    div_req.start       = 1'b1;
                    state_next          = tts_pkg::ST_DIVW;
                end
            end
            tts_pkg::ST_DIVW: begin
                if (div_rsp.done) begin
                    pend_next.alpha = div_rsp.alpha;
                    pend_v_next     = 1'b1;
                    state_next      = ret_reg;
                end
            end
            tts_pkg::ST_END: begin
                if (!pend_v_reg) begin
                    ev_next    = tts_pkg::EV_STATUS;
                    trunc_next = 1'b0;
                    ret_next   = tts_pkg::ST_END;
                    state_next = tts_pkg::ST_EMIT;
                end else if (out_free) begin
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                    out_v_next    = 1'b1;
                    pend_v_next   = 1'b0;
                    state_next    = tts_pkg::ST_IDLE;
                end
            end
            default: state_next = tts_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: bench/tween_timeline_sequencer_top_tb.sv
// Testbench for the tween timeline sequencer: random and directed items, predicted results.
`timescale 1ns / 100ps

class timeline_scoreboard;
    bit [15:0] delay_reg, duration_reg, rate_reg, limit_reg;
    bit        backward_reg;
    bit [1:0]  wrap_reg;
    bit        active, paused, started, fwd;
    bit [15:0] delay_left, position;
    bit [16:0] cycles, pairs;
    tts_pkg::out_item_t pending_results[$];
    int mismatches;

    function new();
        delay_reg = 16'd0; duration_reg = 16'd1; rate_reg = 16'd256; limit_reg = 16'd0;
        backward_reg = 1'b0; wrap_reg = 2'd0; mismatches = 0;
        reload();
    endfunction

    function bit [16:0] dur_eff();
        return (duration_reg == 16'd0) ? 17'd1 : {1'b0, duration_reg};
    endfunction

    function void write_reg(bit [2:0] idx, bit [15:0] val);
        case (idx)
            tts_pkg::REG_DELAY:    delay_reg = val;
            tts_pkg::REG_DURATION: duration_reg = val;
            tts_pkg::REG_RATE:     rate_reg = val;
            tts_pkg::REG_BACKWARD: backward_reg = val[0];
            tts_pkg::REG_WRAP:     wrap_reg = val[1:0];
            tts_pkg::REG_LIMIT:    limit_reg = val;
            default: ;
        endcase
    endfunction

    function void reload();
        active = 1'b1; paused = 1'b0; started = 1'b0;
        delay_left = delay_reg;
        position = backward_reg ? 16'(dur_eff()) : 16'd0;
        fwd = !backward_reg;
        cycles = 17'd0; pairs = 17'd0;
    endfunction

    function void push_result(bit [2:0] ev, bit trunc);
        tts_pkg::out_item_t r;
        longint unsigned a;
        a = ({48'd0, position} << 16) / 64'(dur_eff());
        if (a > 65536) a = 65536;
        r.event_res = ev; r.position = position; r.alpha = a[16:0];
        r.running = active; r.truncated = trunc; r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    // returns 0 when the timeline completed
    function bit take_boundary();
        if (wrap_reg == tts_pkg::WRAP_LOOP) begin
            if (cycles < 65535) cycles++;
            push_result(tts_pkg::EV_LOOPED, 1'b0);
            if (limit_reg > 0 && cycles >= limit_reg) begin
                active = 1'b0; push_result(tts_pkg::EV_COMPLETED, 1'b0); return 1'b0;
            end
            position = backward_reg ? 16'(dur_eff()) : 16'd0;
            fwd = !backward_reg;
            return 1'b1;
        end
        if (wrap_reg == tts_pkg::WRAP_PINGPONG) begin
            fwd = !fwd;
            push_result(tts_pkg::EV_TURNED, 1'b0);
            if (!fwd) begin
                if (pairs < 65535) pairs++;
            end else if (limit_reg > 0 && pairs >= limit_reg) begin
                active = 1'b0; push_result(tts_pkg::EV_COMPLETED, 1'b0); return 1'b0;
            end
            position = fwd ? 16'd0 : 16'(dur_eff());
            return 1'b1;
        end
        active = 1'b0; push_result(tts_pkg::EV_COMPLETED, 1'b0);
        return 1'b0;
    endfunction

    function void advance_time(bit [15:0] elapsed);
        longint unsigned remain, dd, ttb;
        int wraps;
        wraps = 0;
        if (!active || paused) return;
        if (!started) begin
            started = 1'b1;
            if (backward_reg) push_result(tts_pkg::EV_START_FINAL, 1'b0);
        end
        remain = (64'(elapsed) * 64'(rate_reg)) >> 8;
        if (remain > 65535) remain = 65535;
        if (remain == 0) return;
        if (delay_left > 0) begin
            if (remain < 64'(delay_left)) begin
                delay_left = 16'(64'(delay_left) - remain); return;
            end
            remain -= 64'(delay_left); delay_left = 16'd0;
        end
        dd = 64'(dur_eff());
        while (remain > 0 && active) begin
            if (wraps >= tts_pkg::DEF_MAX_WRAPS) begin
                push_result(tts_pkg::EV_STATUS, 1'b1); return;
            end
            if (fwd) begin
                if (64'(position) + remain < dd) begin
                    position = 16'(64'(position) + remain);
                    push_result(tts_pkg::EV_UPDATE, 1'b0); return;
                end
                ttb = (64'(position) > dd) ? 64'(position) - dd : dd - 64'(position);
                position = 16'(dd);
            end else begin
                if (remain < 64'(position)) begin
                    position = 16'(64'(position) - remain);
                    push_result(tts_pkg::EV_UPDATE, 1'b0); return;
                end
                ttb = 64'(position); position = 16'd0;
            end
            push_result(tts_pkg::EV_UPDATE, 1'b0);
            remain = (remain > ttb) ? remain - ttb : 64'd0;
            wraps++;
            if (!take_boundary()) return;
        end
    endfunction

    function void note_input(tts_pkg::in_item_t it);
        int n0;
        n0 = pending_results.size();
        case (it.kind)
            tts_pkg::KIND_TICK:   advance_time(it.elapsed);
            tts_pkg::KIND_PAUSE:  paused = 1'b1;
            tts_pkg::KIND_RESUME: paused = 1'b0;
            tts_pkg::KIND_CANCEL:
                if (active) begin
                    active = 1'b0;
                    push_result(it.apply_final ? tts_pkg::EV_CANCEL_FINAL
                                               : tts_pkg::EV_CANCEL_PLAIN, 1'b0);
                end
            tts_pkg::KIND_RESTART: reload();
            default: ;
        endcase
        if (pending_results.size() == n0) push_result(tts_pkg::EV_STATUS, 1'b0);
        pending_results[pending_results.size()-1].last = 1'b1;
    endfunction

    function void check_result(tts_pkg::out_item_t got);
        tts_pkg::out_item_t exp_r;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        exp_r = pending_results.pop_front();
        if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
        end
    endfunction
endclass

module tween_timeline_sequencer_top_tb;

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [tts_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tts_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic s_valid, s_ready, m_valid, m_ready;
    tts_pkg::in_item_t s_data;
    tts_pkg::out_item_t m_data;

    timeline_scoreboard timeline_sb;
    int idle_cycles;
    bit stall_on;

    localparam int WATCHDOG = 20000;

    tween_timeline_sequencer_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        timeline_sb = new();
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) timeline_sb.note_input(s_data);
            if (m_valid && m_ready) timeline_sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("tween_timeline_sequencer_top_tb: FAIL");
            $finish;
        end
    end

    // receiver: stretches of random stalls and stretches of none
    initial begin
        int seg;
        m_ready = 1'b0;
        forever begin
            seg = int'($urandom_range(5, 60));
            stall_on = $urandom_range(0, 2) != 0;
            repeat (seg) begin
                @(negedge aclk);
                m_ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
        end
    end

    task automatic write_reg(logic [tts_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        timeline_sb.write_reg(idx, val);
    endtask

    task automatic send_item(logic [2:0] kind, logic [15:0] elapsed, logic fin);
        tts_pkg::in_item_t it;
        it.kind = kind; it.elapsed = elapsed; it.apply_final = fin;
        s_valid <= 1'b1; s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (timeline_sb.pending_results.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic configure(logic [15:0] dl, logic [15:0] du, logic [15:0] rt,
                             logic bw, logic [1:0] wm, logic [15:0] lim);
        drain();
        write_reg(tts_pkg::REG_DELAY, dl);
        write_reg(tts_pkg::REG_DURATION, du);
        write_reg(tts_pkg::REG_RATE, rt);
        write_reg(tts_pkg::REG_BACKWARD, {15'd0, bw});
        write_reg(tts_pkg::REG_WRAP, {14'd0, wm});
        write_reg(tts_pkg::REG_LIMIT, lim);
        send_item(tts_pkg::KIND_RESTART, 16'($urandom), 1'($urandom));
    endtask

    task automatic random_item();
        int r;
        logic [15:0] el;
        r = int'($urandom_range(0, 99));
        case ($urandom_range(0, 3))
            0: el = 16'($urandom);
            1: el = 16'($urandom_range(0, 8));
            default: el = 16'($urandom_range(0, 300));
        endcase
        if (r < 80) send_item(tts_pkg::KIND_TICK, el, 1'($urandom));
        else if (r < 85) send_item(tts_pkg::KIND_PAUSE, 16'($urandom), 1'($urandom));
        else if (r < 90) send_item(tts_pkg::KIND_RESUME, 16'($urandom), 1'($urandom));
        else if (r < 93) send_item(tts_pkg::KIND_CANCEL, 16'($urandom), 1'($urandom));
        else if (r < 98) send_item(tts_pkg::KIND_RESTART, 16'($urandom), 1'($urandom));
        else send_item(3'($urandom_range(5, 7)), 16'($urandom), 1'($urandom));
    endtask

    initial begin
        int burst;
        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
        s_valid = 1'b0; s_data = '0; idle_cycles = 0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // defaults: once mode, duration one
        send_item(tts_pkg::KIND_TICK, 16'd0, 1'b0);
        send_item(tts_pkg::KIND_TICK, 16'd1, 1'b0);
        send_item(tts_pkg::KIND_TICK, 16'hFFFF, 1'b0);
        send_item(tts_pkg::KIND_CANCEL, 16'd0, 1'b1);
        send_item(tts_pkg::KIND_RESTART, 16'd0, 1'b0);
        send_item(tts_pkg::KIND_CANCEL, 16'd0, 1'b0);
        send_item(tts_pkg::KIND_CANCEL, 16'hFFFF, 1'b1);
        send_item(3'd7, 16'hFFFF, 1'b1);
        configure(16'd5, 16'd10, 16'd256, 1'b1, tts_pkg::WRAP_LOOP, 16'd0);
        send_item(tts_pkg::KIND_PAUSE, 16'd0, 1'b0);
        send_item(tts_pkg::KIND_TICK, 16'd20, 1'b0);
        send_item(tts_pkg::KIND_RESUME, 16'd0, 1'b0);
        send_item(tts_pkg::KIND_TICK, 16'd3, 1'b0);
        send_item(tts_pkg::KIND_TICK, 16'd200, 1'b0);
        send_item(tts_pkg::KIND_TICK, 16'hFFFF, 1'b0);
        configure(16'd0, 16'd7, 16'hFFFF, 1'b0, tts_pkg::WRAP_PINGPONG, 16'd2);
        send_item(tts_pkg::KIND_TICK, 16'hFFFF, 1'b0);
        configure(16'hFFFF, 16'hFFFF, 16'd1, 1'b0, 2'd3, 16'hFFFF);
        send_item(tts_pkg::KIND_TICK, 16'hFFFF, 1'b0);
        send_item(tts_pkg::KIND_TICK, 16'd255, 1'b0);
        // duration lowered below the current position
        configure(16'd0, 16'd100, 16'd256, 1'b1, tts_pkg::WRAP_PINGPONG, 16'd0);
        drain();
        write_reg(tts_pkg::REG_DURATION, 16'd0);
        send_item(tts_pkg::KIND_TICK, 16'd7, 1'b0);
        send_item(tts_pkg::KIND_TICK, 16'd3, 1'b0);

        for (int ph = 0; ph < 10; ph++) begin
            configure($urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 400)) : 16'd0,
                      ph == 0 ? 16'hFFFF : 16'($urandom_range(0, 200)),
                      ph == 1 ? 16'hFFFF : 16'($urandom_range(0, 2) == 0 ?
                          $urandom : $urandom_range(64, 512)),
                      1'($urandom), 2'($urandom_range(0, 3)),
                      16'($urandom_range(0, 1) ? $urandom_range(0, 4) : 0));
            for (int k = 0; k < 45;) begin
                burst = int'($urandom_range(1, 12));
                for (int b = 0; b < burst && k < 45; b++, k++) random_item();
                s_valid <= 1'b0;
                if (ph == 4 && k > 20) drain();
                repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 40) : 0)
                    @(negedge aclk);
            end
        end

        s_valid <= 1'b0;
        while (timeline_sb.pending_results.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (timeline_sb.mismatches == 0 && timeline_sb.pending_results.size() == 0)
            $display("tween_timeline_sequencer_top_tb: PASS");
        else
            $display("tween_timeline_sequencer_top_tb: FAIL");
        $finish;
    end
endmodule

// File: tween_timeline_sequencer_top.f
hdl/tts_pkg.sv
hdl/tts_alpha_div.sv
hdl/tts_ctrl.sv
hdl/tween_timeline_sequencer_top.sv
bench/tween_timeline_sequencer_top_tb.sv
